/* rtl/core/spq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int ID_BITS     = 16;
  localparam int PRI_BITS    = 8;
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_BITS    = 7;
  localparam int STAT_BITS   = 2;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [STAT_BITS-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    CTL_IDLE   = 1'b0,
    CTL_RESULT = 1'b1
  } ctl_state_e;

  // command from controller to datapath
  typedef struct packed {
    logic load;
    logic pop;
  } spq_cmd_t;

endpackage
`default_nettype wire

/* rtl/core/sorted_priority_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue of (id, priority) pairs held in sorted order
//
// Input channel carries one operation per transfer: a push of entry_id with
// priority_req, or a pop of the head entry. Larger priorities leave first,
// equal priorities leave in arrival order. Each operation gives exactly one
// result transfer with status (ok, full on push, empty on pop), the popped
// id (zero unless a pop succeeded) and the occupancy after the operation.
// The result is registered on the edge that takes the operation. Throughput
// is one operation per cycle; every slot compares and shifts in parallel
// with its neighbours. A new operation is taken while a result waits, as
// long as the receiver is not stalling; while the receiver stalls, the
// result holds and the input is stalled too. Reset empties the queue and
// drops any held result; slot contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 command_i,
  input  wire logic [ID_BITS-1:0]   entry_id_i,
  input  wire logic [PRI_BITS-1:0]  priority_req_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [STAT_BITS-1:0]      status_o,
  output logic [ID_BITS-1:0]        popped_id_o,
  output logic [OCC_BITS-1:0]       occupancy_o
);

  spq_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  spq_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .entry_id_i     (entry_id_i),
    .priority_req_i (priority_req_i),
    .status_o       (status_o),
    .popped_id_o    (popped_id_o),
    .occupancy_o    (occupancy_o)
  );

endmodule
`default_nettype wire

/* rtl/core/spq_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: accepts operations and tracks the held result
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     command_i,
  input  wire logic     out_stall_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  output spq_cmd_t      cmd_o
);

  ctl_state_e state_q, state_d;
  logic       accept;

  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      CTL_IDLE: begin
        if (accept) begin
          state_d = CTL_RESULT;
        end
      end
      CTL_RESULT: begin
        if (accept) begin
          state_d = CTL_RESULT;
        end else if (!out_stall_i) begin
          state_d = CTL_IDLE;
        end
      end
      default: state_d = CTL_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      CTL_IDLE: begin
        in_stall_o  = 1'b0;
        out_valid_o = 1'b0;
      end
      CTL_RESULT: begin
        in_stall_o  = out_stall_i;
        out_valid_o = 1'b1;
      end
      default: begin
        in_stall_o  = 1'b1;
        out_valid_o = 1'b0;
      end
    endcase
    cmd_o.load = in_valid_i && !in_stall_o;
    cmd_o.pop  = (cmd_e'(command_i) == CMD_POP);
  end

endmodule
`default_nettype wire

/* rtl/core/spq_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted slot array with per-slot compare and shift, plus result registers
// ----------------------------------------------------------------------------
module spq_datapath
  import spq_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire spq_cmd_t            cmd_i,
  input  wire logic [ID_BITS-1:0]  entry_id_i,
  input  wire logic [PRI_BITS-1:0] priority_req_i,
  output logic [STAT_BITS-1:0]     status_o,
  output logic [ID_BITS-1:0]       popped_id_o,
  output logic [OCC_BITS-1:0]      occupancy_o
);

  logic [ID_BITS-1:0]  id_q  [QUEUE_DEPTH];
  logic [ID_BITS-1:0]  id_d  [QUEUE_DEPTH];
  logic [PRI_BITS-1:0] pri_q [QUEUE_DEPTH];
  logic [PRI_BITS-1:0] pri_d [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] gt;

  logic [CNT_BITS-1:0] count_q, count_d;
  status_e             status_q, status_d;
  logic [ID_BITS-1:0]  popped_q, popped_d;

  logic full, empty, do_push, do_pop;

  assign full    = (count_q == CNT_BITS'(QUEUE_DEPTH));
  assign empty   = (count_q == '0);
  assign do_push = cmd_i.load && !cmd_i.pop && !full;
  assign do_pop  = cmd_i.load && cmd_i.pop && !empty;

  // gt marks slots where the new entry outranks the stored one or the slot is unused; the first such slot takes it
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      gt[i] = (count_q <= CNT_BITS'(i)) || (priority_req_i > pri_q[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      id_d[i]  = id_q[i];
      pri_d[i] = pri_q[i];
      if (do_push) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          id_d[i]  = id_q[(i > 0) ? i - 1 : 0];
          pri_d[i] = pri_q[(i > 0) ? i - 1 : 0];
        end else if (gt[i]) begin
          id_d[i]  = entry_id_i;
          pri_d[i] = priority_req_i;
        end
      end else if (do_pop && i < QUEUE_DEPTH - 1) begin
        id_d[i]  = id_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        pri_d[i] = pri_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_d  = count_q;
    status_d = STAT_OK;
    popped_d = '0;
    if (cmd_i.pop) begin
      if (empty) begin
        status_d = STAT_EMPTY;
      end else begin
        popped_d = id_q[0];
        count_d  = count_q - CNT_BITS'(1);
      end
    end else begin
      if (full) begin
        status_d = STAT_FULL;
      end else begin
        count_d = count_q + CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      id_q[i]  <= id_d[i];
      pri_q[i] <= pri_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.load) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q <= status_d;
      popped_q <= popped_d;
    end
  end

  assign status_o    = status_q;
  assign popped_id_o = popped_q;
  assign occupancy_o = OCC_BITS'(count_q);

endmodule
`default_nettype wire

/* rtl/core/spq_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the results of the sorted priority queue
// ----------------------------------------------------------------------------
module spq_checker
  import spq_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic [STAT_BITS-1:0] status_o,
  input wire logic [ID_BITS-1:0]  popped_id_o,
  input wire logic [OCC_BITS-1:0] occupancy_o
);

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STAT_OK || status_o == STAT_FULL ||
                     status_o == STAT_EMPTY))
    else $error("illegal status code");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STAT_FULL) |-> occupancy_o == OCC_BITS'(QUEUE_DEPTH))
    else $error("full status without full occupancy");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STAT_EMPTY) |-> (occupancy_o == '0 && popped_id_o == '0))
    else $error("empty status with entries or id");

  a_id_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && popped_id_o != '0) |-> status_o == STAT_OK)
    else $error("popped id on a refused operation");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o) &&
                                      $stable(popped_id_o) && $stable(occupancy_o)))
    else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .popped_id_o (popped_id_o),
  .occupancy_o (occupancy_o)
);
`default_nettype wire

/* dv/sorted_priority_queue_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Self-checking bench for the sorted priority queue
//
// A short table of pushes and pops covers the empty queue, ties of equal
// priority, the extreme ids and priorities and insertion in the middle. It is
// followed by random phases that fill, drain or churn the queue, so the full
// and empty cases come up many times. A shadow queue predicts every result
// the table does not give, and each result transfer is checked field by
// field against the oldest expectation. Both sides pause and stall at random.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int RANDOM_ITEMS = 1650;
  localparam int CYCLE_LIMIT  = 1_000_000;

  typedef struct packed {
    status_e               status;
    logic [ID_BITS-1:0]    popped_id;
    logic [OCC_BITS-1:0]   occupancy;
  } outcome_t;

  typedef struct {
    cmd_e                  cmd;
    logic [ID_BITS-1:0]    id;
    logic [PRI_BITS-1:0]   pri;
    bit                    typed;
    outcome_t              want;
  } step_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  command_i      = CMD_PUSH;
  logic [ID_BITS-1:0]    entry_id_i     = '0;
  logic [PRI_BITS-1:0]   priority_req_i = '0;
  logic                  out_stall_i    = 1'b0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [STAT_BITS-1:0]  status_o;
  logic [ID_BITS-1:0]    popped_id_o;
  logic [OCC_BITS-1:0]   occupancy_o;

  // typed expectation travelling with the current item, if any
  bit                    item_typed = 1'b0;
  outcome_t              item_want  = '0;

  // shadow copy of the queue contents
  logic [ID_BITS-1:0]    shadow_ids [QUEUE_DEPTH];
  logic [PRI_BITS-1:0]   shadow_pris [QUEUE_DEPTH];
  int                    shadow_count = 0;

  outcome_t              pending_results [$];
  int                    mismatches = 0;
  int                    cycles = 0;

  step_t directed_steps [14] = '{
    '{CMD_POP,  16'h0000, 8'h00, 1'b1, '{STAT_EMPTY, 16'h0000, 7'd0}},
    '{CMD_PUSH, 16'hFFFF, 8'h00, 1'b1, '{STAT_OK,    16'h0000, 7'd1}},
    '{CMD_PUSH, 16'h0000, 8'hFF, 1'b1, '{STAT_OK,    16'h0000, 7'd2}},
    '{CMD_PUSH, 16'h1234, 8'hFF, 1'b1, '{STAT_OK,    16'h0000, 7'd3}},
    '{CMD_PUSH, 16'hA5A5, 8'h80, 1'b1, '{STAT_OK,    16'h0000, 7'd4}},
    '{CMD_PUSH, 16'h5A5A, 8'h7F, 1'b1, '{STAT_OK,    16'h0000, 7'd5}},
    '{CMD_POP,  16'hFFFF, 8'hFF, 1'b1, '{STAT_OK,    16'h0000, 7'd4}},
    '{CMD_POP,  16'h0000, 8'h00, 1'b1, '{STAT_OK,    16'h1234, 7'd3}},
    '{CMD_POP,  16'h0000, 8'h00, 1'b1, '{STAT_OK,    16'hA5A5, 7'd2}},
    '{CMD_POP,  16'h0000, 8'h00, 1'b1, '{STAT_OK,    16'h5A5A, 7'd1}},
    '{CMD_POP,  16'h0000, 8'h00, 1'b1, '{STAT_OK,    16'hFFFF, 7'd0}},
    '{CMD_POP,  16'hBEEF, 8'h55, 1'b1, '{STAT_EMPTY, 16'h0000, 7'd0}},
    '{CMD_PUSH, 16'h8001, 8'h01, 1'b0, '0},
    '{CMD_POP,  16'h0000, 8'h00, 1'b0, '0}
  };

  sorted_priority_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .entry_id_i     (entry_id_i),
    .priority_req_i (priority_req_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .popped_id_o    (popped_id_o),
    .occupancy_o    (occupancy_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic void shadow_apply(input cmd_e cmd, input logic [ID_BITS-1:0] id,
                                       input logic [PRI_BITS-1:0] pri,
                                       output outcome_t res);
    int pos;
    res = '{STAT_OK, '0, '0};
    if (cmd == CMD_PUSH) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        // first held entry of strictly lower priority
        pos = shadow_count;
        for (int i = shadow_count - 1; i >= 0; i--) begin
          if (pri > shadow_pris[i]) pos = i;
        end
        for (int i = shadow_count; i > pos; i--) begin
          shadow_ids[i]  = shadow_ids[i-1];
          shadow_pris[i] = shadow_pris[i-1];
        end
        shadow_ids[pos]  = id;
        shadow_pris[pos] = pri;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        res.status = STAT_EMPTY;
      end else begin
        res.popped_id = shadow_ids[0];
        for (int i = 0; i + 1 < shadow_count; i++) begin
          shadow_ids[i]  = shadow_ids[i+1];
          shadow_pris[i] = shadow_pris[i+1];
        end
        shadow_count--;
      end
    end
    res.occupancy = OCC_BITS'(shadow_count);
  endfunction

  // mostly short, now and then long
  function automatic int pause_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return $urandom_range(1, 2);
    if (p < 95) return $urandom_range(3, 8);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [PRI_BITS-1:0] pick_priority();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return PRI_BITS'($urandom_range(0, 255));
      5, 6, 7:       return PRI_BITS'($urandom_range(0, 3));
      8:             return '1;
      default:       return '0;
    endcase
  endfunction

  task automatic issue_op(input cmd_e cmd, input logic [ID_BITS-1:0] id,
                          input logic [PRI_BITS-1:0] pri, input bit typed,
                          input outcome_t want, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    entry_id_i     <= id;
    priority_req_i <= pri;
    item_typed     <= typed;
    item_want      <= want;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // result check and prediction
  always @(posedge clk_i) begin
    outcome_t want;
    outcome_t model;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            mismatches++;
          end
          if (popped_id_o !== want.popped_id) begin
            $error("popped_id: expected %0h, got %0h", want.popped_id, popped_id_o);
            mismatches++;
          end
          if (occupancy_o !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy_o);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        shadow_apply(cmd_e'(command_i), entry_id_i, priority_req_i, model);
        pending_results.push_back(item_typed ? item_want : model);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver stalls
  initial begin
    int run;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      out_stall_i <= 1'b0;
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      repeat (run) @(negedge clk_i);
      out_stall_i <= 1'b1;
      repeat (pause_len()) @(negedge clk_i);
    end
  end

  initial begin
    int  random_sent;
    int  kind;
    int  len;
    int  push_pct;
    bit  gaps_on;
    random_sent = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_steps[row]) begin
      issue_op(directed_steps[row].cmd, directed_steps[row].id, directed_steps[row].pri,
               directed_steps[row].typed, directed_steps[row].want,
               ($urandom_range(0, 2) == 0) ? pause_len() : 0);
    end

    // churn, fill towards full, or drain towards empty
    while (random_sent < RANDOM_ITEMS) begin
      kind    = $urandom_range(0, 9);
      gaps_on = ($urandom_range(0, 3) != 0);
      if (kind < 4) begin
        push_pct = 50;
        len      = $urandom_range(20, 80);
      end else if (kind < 7) begin
        push_pct = 90;
        len      = $urandom_range(80, 110);
      end else begin
        push_pct = 10;
        len      = $urandom_range(80, 110);
      end
      for (int k = 0; k < len && random_sent < RANDOM_ITEMS; k++) begin
        issue_op(($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP,
                 ID_BITS'($urandom()), pick_priority(), 1'b0, '0,
                 (gaps_on && $urandom_range(0, 1) == 0) ? pause_len() : 0);
        random_sent++;
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
